[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kfd_pkg.sv]
package kfd_pkg;

    localparam int DUR_W       = 16;
    localparam int PRE_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int BIT_CNT_W   = 7;
    localparam int KEY_W       = 64;
    localparam int SERIAL_W    = 24;
    localparam int BUTTON_W    = 4;
    localparam int COUNT_W     = 16;
    localparam int DIGIT_W_DEF = 4;

    localparam logic [BIT_CNT_W-1:0] FRAME_BITS = BIT_CNT_W'(64);
    localparam logic [PRE_W-1:0]     PRE_MAX    = {PRE_W{1'b1}};

    localparam logic [DUR_W-1:0] RST_SHORT_US   = DUR_W'(800);
    localparam logic [DUR_W-1:0] RST_LONG_US    = DUR_W'(1600);
    localparam logic [DUR_W-1:0] RST_TOL_US     = DUR_W'(250);
    localparam logic [DUR_W-1:0] RST_GAP_MIN_US = DUR_W'(2000);
    localparam logic [DUR_W-1:0] RST_GAP_MAX_US = DUR_W'(3500);
    localparam logic [DUR_W-1:0] RST_END_GAP_US = DUR_W'(3000);
    localparam logic [PRE_W-1:0] RST_MIN_PRE    = PRE_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT   = 3'd0,
        CFG_LONG    = 3'd1,
        CFG_TOL     = 3'd2,
        CFG_GAP_MIN = 3'd3,
        CFG_GAP_MAX = 3'd4,
        CFG_END_GAP = 3'd5,
        CFG_MIN_PRE = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_GAP,
        PH_SYNC,
        PH_BIT_HIGH,
        PH_BIT_LOW
    } t_phase;

    typedef struct packed {
        logic [DUR_W-1:0] short_us;
        logic [DUR_W-1:0] long_us;
        logic [DUR_W-1:0] tol_us;
        logic [DUR_W-1:0] gap_min_us;
        logic [DUR_W-1:0] gap_max_us;
        logic [DUR_W-1:0] end_gap_us;
    } t_times;

    typedef struct packed {
        logic done;
        logic near_short;
        logic near_long;
        logic in_gap;
        logic above_end;
    } t_cmp;

    typedef struct packed {
        logic busy;
        logic ready;
    } t_uns_sts;

endpackage

[rtl/kfd_digit_cmp.sv]
module kfd_digit_cmp #(
    parameter int DIGIT_W = kfd_pkg::DIGIT_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kfd_pkg::DUR_W-1:0]  i_duration,
    input  kfd_pkg::t_times            i_times,
    output kfd_pkg::t_cmp              o_cmp
);

    localparam int NUM_DIGITS = kfd_pkg::DUR_W / DIGIT_W;
    localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

    function automatic logic [DIGIT_W:0] dsub(input logic [DIGIT_W-1:0] a,
                                              input logic [DIGIT_W-1:0] b,
                                              input logic               bin);
        return {1'b0, a} - {1'b0, b} - {{DIGIT_W{1'b0}}, bin};
    endfunction

    logic [kfd_pkg::DUR_W-1:0] r_d, r_s, r_l, r_tol, r_gmin, r_gmax, r_end;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_run;
    logic                      r_done;

    // borrows: d-s, (d-s)-t, s-d, (s-d)-t, same for long, gmin-d, d-gmax, end-d
    logic r_b_ds, r_b_dst, r_b_sd, r_b_sdt;
    logic r_b_dl, r_b_dlt, r_b_ld, r_b_ldt;
    logic r_b_gmin, r_b_gmax, r_b_end;

    logic [DIGIT_W:0] n_ds, n_dst, n_sd, n_sdt;
    logic [DIGIT_W:0] n_dl, n_dlt, n_ld, n_ldt;
    logic [DIGIT_W:0] n_gmin, n_gmax, n_end;

    always_comb begin
        n_ds   = dsub(r_d[DIGIT_W-1:0], r_s[DIGIT_W-1:0], r_b_ds);
        n_dst  = dsub(n_ds[DIGIT_W-1:0], r_tol[DIGIT_W-1:0], r_b_dst);
        n_sd   = dsub(r_s[DIGIT_W-1:0], r_d[DIGIT_W-1:0], r_b_sd);
        n_sdt  = dsub(n_sd[DIGIT_W-1:0], r_tol[DIGIT_W-1:0], r_b_sdt);
        n_dl   = dsub(r_d[DIGIT_W-1:0], r_l[DIGIT_W-1:0], r_b_dl);
        n_dlt  = dsub(n_dl[DIGIT_W-1:0], r_tol[DIGIT_W-1:0], r_b_dlt);
        n_ld   = dsub(r_l[DIGIT_W-1:0], r_d[DIGIT_W-1:0], r_b_ld);
        n_ldt  = dsub(n_ld[DIGIT_W-1:0], r_tol[DIGIT_W-1:0], r_b_ldt);
        n_gmin = dsub(r_gmin[DIGIT_W-1:0], r_d[DIGIT_W-1:0], r_b_gmin);
        n_gmax = dsub(r_d[DIGIT_W-1:0], r_gmax[DIGIT_W-1:0], r_b_gmax);
        n_end  = dsub(r_end[DIGIT_W-1:0], r_d[DIGIT_W-1:0], r_b_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == LAST_DIGIT)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d      <= i_duration;
            r_s      <= i_times.short_us;
            r_l      <= i_times.long_us;
            r_tol    <= i_times.tol_us;
            r_gmin   <= i_times.gap_min_us;
            r_gmax   <= i_times.gap_max_us;
            r_end    <= i_times.end_gap_us;
            r_cnt    <= '0;
            r_b_ds   <= 1'b0;
            r_b_dst  <= 1'b0;
            r_b_sd   <= 1'b0;
            r_b_sdt  <= 1'b0;
            r_b_dl   <= 1'b0;
            r_b_dlt  <= 1'b0;
            r_b_ld   <= 1'b0;
            r_b_ldt  <= 1'b0;
            r_b_gmin <= 1'b0;
            r_b_gmax <= 1'b0;
            r_b_end  <= 1'b0;
        end else if (r_run) begin
            r_d      <= r_d >> DIGIT_W;
            r_s      <= r_s >> DIGIT_W;
            r_l      <= r_l >> DIGIT_W;
            r_tol    <= r_tol >> DIGIT_W;
            r_gmin   <= r_gmin >> DIGIT_W;
            r_gmax   <= r_gmax >> DIGIT_W;
            r_end    <= r_end >> DIGIT_W;
            r_cnt    <= r_cnt + CNT_W'(1);
            r_b_ds   <= n_ds[DIGIT_W];
            r_b_dst  <= n_dst[DIGIT_W];
            r_b_sd   <= n_sd[DIGIT_W];
            r_b_sdt  <= n_sdt[DIGIT_W];
            r_b_dl   <= n_dl[DIGIT_W];
            r_b_dlt  <= n_dlt[DIGIT_W];
            r_b_ld   <= n_ld[DIGIT_W];
            r_b_ldt  <= n_ldt[DIGIT_W];
            r_b_gmin <= n_gmin[DIGIT_W];
            r_b_gmax <= n_gmax[DIGIT_W];
            r_b_end  <= n_end[DIGIT_W];
        end
    end

    always_comb begin
        o_cmp.done       = r_done;
        o_cmp.near_short = r_b_ds ? r_b_sdt : r_b_dst;
        o_cmp.near_long  = r_b_dl ? r_b_ldt : r_b_dlt;
        o_cmp.in_gap     = r_b_gmin && r_b_gmax;
        o_cmp.above_end  = r_b_end;
    end

endmodule

[rtl/kfd_unscramble.sv]
module kfd_unscramble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kfd_pkg::KEY_W-1:0]     i_frame,
    input  logic                          i_ack,
    output kfd_pkg::t_uns_sts             o_sts,
    output logic [kfd_pkg::KEY_W-1:0]     o_frame_key,
    output logic [kfd_pkg::SERIAL_W-1:0]  o_serial_number,
    output logic [kfd_pkg::BUTTON_W-1:0]  o_button_code,
    output logic [kfd_pkg::COUNT_W-1:0]   o_press_count
);

    function automatic logic [7:0] low_count(input logic [kfd_pkg::KEY_W-1:0] f);
        logic [7:0] b4, b5, b6;
        b4 = f[31:24];
        b5 = f[23:16];
        b6 = f[15:8];
        return ~{b5[7], b5[6], b6[1], b6[0], b5[1], b5[0], b4[7], b4[6]};
    endfunction

    function automatic logic [4:0] mod24(input logic [7:0] x);
        logic [8:0] v;
        v = {1'b0, x};
        if (v >= 9'd192) v = v - 9'd192;
        if (v >= 9'd96)  v = v - 9'd96;
        if (v >= 9'd48)  v = v - 9'd48;
        if (v >= 9'd24)  v = v - 9'd24;
        return v[4:0];
    endfunction

    logic [kfd_pkg::KEY_W-1:0]    r_frame;
    logic [kfd_pkg::SERIAL_W-1:0] r_w;
    logic [4:0]                   r_steps;
    logic                         r_busy;

    logic [7:0] s_lo_in;
    logic [7:0] s_b5, s_b6, s_b7;
    logic [7:0] s_sh1, s_sh2, s_t1, s_t2, s_hi;

    assign s_lo_in = low_count(i_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (i_ack) begin
            r_busy <= 1'b0;
        end
    end

    // serial rotate left, one place a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_frame <= i_frame;
            r_w     <= {i_frame[39:32], i_frame[55:48], i_frame[47:40]};
            r_steps <= mod24(s_lo_in + 8'd4);
        end else if (r_busy && (r_steps != 5'd0)) begin
            r_w     <= {r_w[kfd_pkg::SERIAL_W-2:0], r_w[kfd_pkg::SERIAL_W-1]};
            r_steps <= r_steps - 5'd1;
        end
    end

    always_comb begin
        s_b5  = r_frame[23:16];
        s_b6  = r_frame[15:8];
        s_b7  = r_frame[7:0];
        s_sh1 = {s_b7[3:0], s_b5[3:2], s_b6[7], s_b6[6]};
        s_sh2 = {s_b6[5:2], s_b7[7:4]};
        s_t1  = r_w[15:8] ^ s_sh1;
        s_t2  = r_w[7:0] ^ s_sh2;
        s_hi  = ~{s_t1[1], s_t1[0], s_t2[3], s_t2[2], s_t1[5], s_t1[4], s_t2[7], s_t2[6]};
    end

    assign o_sts.busy      = r_busy;
    assign o_sts.ready     = r_busy && (r_steps == 5'd0);
    assign o_frame_key     = r_frame;
    assign o_serial_number = r_frame[55:32];
    assign o_button_code   = r_frame[59:56];
    assign o_press_count   = {s_hi, low_count(r_frame)};

endmodule

[rtl/keyfob_pulse_width_frame_decoder.sv]
// Pulse-width keyfob frame decoder. Each input beat is one demodulated pulse (level and
// duration in microseconds); after a preamble, gap, sync and 64 data bits, an end gap
// delivers one output beat with the whole frame, the serial number, the button and the
// unscrambled press counter. Timing is checked by a digit-serial comparator that walks
// the duration and all time thresholds DIGIT_WIDTH bits a cycle; no pulse is taken while
// the last one is compared. A completed frame then rotates in the one-place-a-cycle counter
// rotator by ((4 + low counter byte) mod 256) mod 24 places, at most 23, and waits there
// until the output register is free; no pulse is taken meanwhile. A finished result waits
// in the output register without holding up later pulses. The user writes the registers by
// index through the write port only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module keyfob_pulse_width_frame_decoder #(
    parameter int DIGIT_WIDTH = kfd_pkg::DIGIT_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kfd_pkg::DUR_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_level,
    input  logic [kfd_pkg::DUR_W-1:0]         i_duration,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [kfd_pkg::KEY_W-1:0]         o_frame_key,
    output logic [kfd_pkg::SERIAL_W-1:0]      o_serial_number,
    output logic [kfd_pkg::BUTTON_W-1:0]      o_button_code,
    output logic [kfd_pkg::COUNT_W-1:0]       o_press_count
);

    kfd_pkg::t_times            r_times;
    logic [kfd_pkg::PRE_W-1:0]  r_min_pre;

    kfd_pkg::t_phase            r_phase, n_phase;
    logic [kfd_pkg::PRE_W-1:0]  r_pre_cnt;
    logic [kfd_pkg::BIT_CNT_W-1:0] r_bits;
    logic [kfd_pkg::KEY_W-1:0]  r_frame;
    logic                       r_busy;
    logic                       r_level;

    logic                       r_out_valid;
    logic [kfd_pkg::KEY_W-1:0]    r_key;
    logic [kfd_pkg::SERIAL_W-1:0] r_serial;
    logic [kfd_pkg::BUTTON_W-1:0] r_button;
    logic [kfd_pkg::COUNT_W-1:0]  r_count;

    kfd_pkg::t_cmp              s_cmp;
    kfd_pkg::t_uns_sts          s_uns;
    logic [kfd_pkg::KEY_W-1:0]    s_uns_key;
    logic [kfd_pkg::SERIAL_W-1:0] s_uns_serial;
    logic [kfd_pkg::BUTTON_W-1:0] s_uns_button;
    logic [kfd_pkg::COUNT_W-1:0]  s_uns_count;

    logic s_accept;
    logic s_pre_load, s_pre_inc, s_bits_clr, s_bit_add, s_bit_val, s_frame_end;
    logic s_uns_start;
    logic s_out_load;

    assign o_in_ready = !r_busy && !s_uns.busy;
    assign s_accept   = i_in_valid && o_in_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times.short_us   <= kfd_pkg::RST_SHORT_US;
            r_times.long_us    <= kfd_pkg::RST_LONG_US;
            r_times.tol_us     <= kfd_pkg::RST_TOL_US;
            r_times.gap_min_us <= kfd_pkg::RST_GAP_MIN_US;
            r_times.gap_max_us <= kfd_pkg::RST_GAP_MAX_US;
            r_times.end_gap_us <= kfd_pkg::RST_END_GAP_US;
            r_min_pre          <= kfd_pkg::RST_MIN_PRE;
        end else if (i_cfg_we) begin
            case (kfd_pkg::t_cfg_idx'(i_cfg_index))
                kfd_pkg::CFG_SHORT:   r_times.short_us   <= i_cfg_data;
                kfd_pkg::CFG_LONG:    r_times.long_us    <= i_cfg_data;
                kfd_pkg::CFG_TOL:     r_times.tol_us     <= i_cfg_data;
                kfd_pkg::CFG_GAP_MIN: r_times.gap_min_us <= i_cfg_data;
                kfd_pkg::CFG_GAP_MAX: r_times.gap_max_us <= i_cfg_data;
                kfd_pkg::CFG_END_GAP: r_times.end_gap_us <= i_cfg_data;
                kfd_pkg::CFG_MIN_PRE: r_min_pre <= i_cfg_data[kfd_pkg::PRE_W-1:0];
                default: ;
            endcase
        end
    end

    kfd_digit_cmp #(
        .DIGIT_W(DIGIT_WIDTH)
    ) u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_duration (i_duration),
        .i_times    (r_times),
        .o_cmp      (s_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_accept) begin
            r_busy <= 1'b1;
        end else if (s_cmp.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_level <= i_level;
        end
    end

    // receive state machine, next state
    always_comb begin
        n_phase = r_phase;
        if (s_cmp.done) begin
            case (r_phase)
                kfd_pkg::PH_IDLE: begin
                    if (r_level && s_cmp.near_long) n_phase = kfd_pkg::PH_PREAMBLE;
                end
                kfd_pkg::PH_PREAMBLE: begin
                    if (s_cmp.near_long) begin
                        n_phase = kfd_pkg::PH_PREAMBLE;
                    end else if (!r_level && s_cmp.in_gap && (r_pre_cnt > r_min_pre)) begin
                        n_phase = kfd_pkg::PH_GAP;
                    end else begin
                        n_phase = kfd_pkg::PH_IDLE;
                    end
                end
                kfd_pkg::PH_GAP: begin
                    n_phase = (r_level && s_cmp.in_gap) ? kfd_pkg::PH_SYNC : kfd_pkg::PH_IDLE;
                end
                kfd_pkg::PH_SYNC: begin
                    n_phase = (!r_level && s_cmp.near_long) ? kfd_pkg::PH_BIT_HIGH
                                                             : kfd_pkg::PH_IDLE;
                end
                kfd_pkg::PH_BIT_HIGH: begin
                    if (r_level && (s_cmp.near_short || s_cmp.near_long)) begin
                        n_phase = kfd_pkg::PH_BIT_LOW;
                    end else begin
                        n_phase = kfd_pkg::PH_IDLE;
                    end
                end
                kfd_pkg::PH_BIT_LOW: begin
                    if (!r_level && (s_cmp.near_short || s_cmp.near_long)) begin
                        n_phase = kfd_pkg::PH_BIT_HIGH;
                    end else begin
                        n_phase = kfd_pkg::PH_IDLE;
                    end
                end
                default: n_phase = kfd_pkg::PH_IDLE;
            endcase
        end
    end

    // receive state machine, actions
    always_comb begin
        s_pre_load  = 1'b0;
        s_pre_inc   = 1'b0;
        s_bits_clr  = 1'b0;
        s_bit_add   = 1'b0;
        s_bit_val   = 1'b0;
        s_frame_end = 1'b0;
        if (s_cmp.done) begin
            case (r_phase)
                kfd_pkg::PH_IDLE: begin
                    s_pre_load = r_level && s_cmp.near_long;
                end
                kfd_pkg::PH_PREAMBLE: begin
                    s_pre_inc = s_cmp.near_long;
                end
                kfd_pkg::PH_SYNC: begin
                    s_bits_clr = !r_level && s_cmp.near_long;
                end
                kfd_pkg::PH_BIT_HIGH: begin
                    if (r_level) begin
                        if (s_cmp.near_short) begin
                            s_bit_add = 1'b1;
                            s_bit_val = 1'b1;
                        end else if (s_cmp.near_long) begin
                            s_bit_add = 1'b1;
                        end else begin
                            s_frame_end = s_cmp.above_end;
                        end
                    end
                end
                kfd_pkg::PH_BIT_LOW: begin
                    s_frame_end = !r_level && !s_cmp.near_short && !s_cmp.near_long
                                  && s_cmp.above_end;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kfd_pkg::PH_IDLE;
            r_pre_cnt <= '0;
            r_bits    <= '0;
        end else begin
            r_phase <= n_phase;
            if (s_pre_load) begin
                r_pre_cnt <= kfd_pkg::PRE_W'(1);
            end else if (s_pre_inc && (r_pre_cnt != kfd_pkg::PRE_MAX)) begin
                r_pre_cnt <= r_pre_cnt + kfd_pkg::PRE_W'(1);
            end
            if (s_bits_clr) begin
                r_bits <= '0;
            end else if (s_bit_add && (r_bits != kfd_pkg::FRAME_BITS)) begin
                r_bits <= r_bits + kfd_pkg::BIT_CNT_W'(1);
            end
        end
    end

    // frame shift register, first bit ends up on top
    always_ff @(posedge i_clk) begin
        if (s_bit_add && (r_bits != kfd_pkg::FRAME_BITS)) begin
            r_frame <= {r_frame[kfd_pkg::KEY_W-2:0], s_bit_val};
        end
    end

    assign s_uns_start = s_frame_end && (r_bits == kfd_pkg::FRAME_BITS);

    kfd_unscramble u_uns (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (s_uns_start),
        .i_frame         (r_frame),
        .i_ack           (s_out_load),
        .o_sts           (s_uns),
        .o_frame_key     (s_uns_key),
        .o_serial_number (s_uns_serial),
        .o_button_code   (s_uns_button),
        .o_press_count   (s_uns_count)
    );

    // output register
    assign s_out_load = s_uns.ready && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_key    <= s_uns_key;
            r_serial <= s_uns_serial;
            r_button <= s_uns_button;
            r_count  <= s_uns_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_key     = r_key;
    assign o_serial_number = r_serial;
    assign o_button_code   = r_button;
    assign o_press_count   = r_count;

    `KFD_ASSERT_NOW(a_cmp_done_in_flight, i_clk, i_rst_n, s_cmp.done, r_busy, "compare result with no pulse in flight")
    `KFD_ASSERT_NOW(a_uns_start_idle, i_clk, i_rst_n, s_uns_start, !s_uns.busy, "frame end while rotator busy")
    `KFD_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, s_accept, !o_in_ready, "second beat taken while pulse in flight")

endmodule
